// File: hw/rtl/sactu_pkg.sv
// Shared types, field widths, codes and helper functions for the cache tag unit.
// Used by the channel interfaces and by the top level, address splitter, lookup and counters.
package sactu_pkg;

	// Defaults of the top-level parameters.
	localparam int unsigned SETS_DEF          = 1024;
	localparam int unsigned WAYS_DEF          = 4;
	localparam int unsigned ADDRESS_WIDTH_DEF = 32;

	// Fixed field widths of the request, response and configuration port.
	localparam int ACTION_W   = 2;
	localparam int ADDR_IN_W  = 32;
	localparam int WAY_OUT_W  = 2;
	localparam int SET_OUT_W  = 10;
	localparam int COUNT_W    = 32;
	localparam int OB_W       = 5;
	localparam int IB_W       = 4;
	localparam int RAW_W      = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	typedef logic [ACTION_W-1:0] action_t;
	localparam action_t ACT_INSTR_FETCH = 2'd2;

	localparam logic [OB_W-1:0] OFFSET_BITS_RST = 5'd3;
	localparam logic [IB_W-1:0] INDEX_BITS_RST  = 4'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPLIT_MODE,
		CFG_FOUR_WAY,
		CFG_OFFSET_BITS,
		CFG_INDEX_BITS
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_MOD,
		ST_READ,
		ST_CMP
	} state_t;

	// Steps of the address splitter.
	typedef struct packed {
		logic load;
		logic div;
		logic mod;
	} split_ctl_t;

	// Update strobe and selection for the hit and miss counters.
	typedef struct packed {
		logic upd;
		logic instr;
		logic hit;
	} cnt_ctl_t;

	function automatic int sactu_idx_w(int sets);
		return (sets > 1) ? $clog2(sets) : 1;
	endfunction

	function automatic int sactu_tag_w(int aw);
		return (aw < ADDR_IN_W) ? aw : ADDR_IN_W;
	endfunction

	function automatic int sactu_ptr_w(int ways);
		return (ways > 1) ? $clog2(ways) : 1;
	endfunction

	// A set count that is a power of two (and above one) needs no reduction step.
	function automatic bit sactu_mod_free(int sets);
		return (sets > 1) && ((sets & (sets - 1)) == 0);
	endfunction

endpackage

// File: hw/rtl/sactu_if.sv
// Request and response channels of the cache tag unit, valid/ready handshake.
// Depends on sactu_pkg for the field widths.
interface sactu_req_if import sactu_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [ACTION_W-1:0]  action;
	logic [ADDR_IN_W-1:0] address;

	modport source (output valid, action, address, input ready);
	modport sink   (input valid, action, address, output ready);
endinterface

interface sactu_rsp_if import sactu_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic                 instruction_side;
	logic [WAY_OUT_W-1:0] way;
	logic [SET_OUT_W-1:0] set_index;
	logic [COUNT_W-1:0]   side_hits;
	logic [COUNT_W-1:0]   side_misses;

	modport source (output valid, hit, instruction_side, way, set_index, side_hits, side_misses,
		input ready);
	modport sink   (input valid, hit, instruction_side, way, set_index, side_hits, side_misses,
		output ready);
endinterface

// File: hw/rtl/split_set_assoc_cache_tags_unit.sv
// Top level of the split/unified set-associative cache tag unit.
// Depends on sactu_pkg, sactu_if, sactu_tag_ram, sactu_addr_split, sactu_lookup, sactu_counters.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-------------------------------------------------
//   req      | in  | valid / ready | action, address
//   rsp      | out | valid / ready | hit, instruction_side, way, set_index,
//            |     |               | side_hits, side_misses
//   cfg      | in  | cfg_write     | cfg_index, cfg_data
//
// One request at a time, stepping through IDLE, READ and CMP when SETS is a power of two,
// through IDLE, DIV, MOD, READ and CMP otherwise (two extra steps reduce the index modulo
// SETS); the tag memory read-modify-write has registered read data. After reset a clearing
// pass writes all 2 * 2**clog2(SETS) rows (2048 by default) before the first request is
// taken. A request may be accepted while the previous response still waits in the output
// register; a lookup that finds the output register full holds until it drains.
module split_set_assoc_cache_tags_unit import sactu_pkg::*; #(
	parameter int SETS          = SETS_DEF,
	parameter int WAYS          = WAYS_DEF,
	parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sactu_req_if.sink             req,
	sactu_rsp_if.source           rsp,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int  IDX_W    = sactu_idx_w(SETS);
	localparam int  TAG_W    = sactu_tag_w(ADDRESS_WIDTH);
	localparam int  PTR_W    = sactu_ptr_w(WAYS);
	localparam int  ROW_W    = PTR_W + WAYS + WAYS * TAG_W;
	localparam int  MEM_AW   = IDX_W + 1;
	localparam bit  MOD_FREE = sactu_mod_free(SETS);

	state_t state_q, state_nx;

	logic            split_mode_q;
	logic            four_way_q;
	logic [OB_W-1:0] offset_bits_q;
	logic [IB_W-1:0] index_bits_q;

	logic [MEM_AW-1:0] clr_q;

	split_ctl_t split_ctl;
	cnt_ctl_t   cnt_ctl;

	logic             instr;
	logic [TAG_W-1:0] tag;
	logic [IDX_W-1:0] set_idx;

	logic              mem_we;
	logic              mem_re;
	logic [MEM_AW-1:0] mem_waddr;
	logic [ROW_W-1:0]  mem_wdata;
	logic [ROW_W-1:0]  mem_rdata;

	logic                 look_hit;
	logic [WAY_OUT_W-1:0] look_way;
	logic [ROW_W-1:0]     new_row;

	logic [COUNT_W-1:0] hits_nx;
	logic [COUNT_W-1:0] misses_nx;

	logic                 out_free;
	logic                 out_load;
	logic                 rsp_valid_q;
	logic                 hit_q;
	logic                 instr_q;
	logic [WAY_OUT_W-1:0] way_q;
	logic [SET_OUT_W-1:0] set_index_q;
	logic [COUNT_W-1:0]   side_hits_q;
	logic [COUNT_W-1:0]   side_misses_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_mode_q  <= 1'b0;
			four_way_q    <= 1'b0;
			offset_bits_q <= OFFSET_BITS_RST;
			index_bits_q  <= INDEX_BITS_RST;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_SPLIT_MODE:  split_mode_q  <= cfg_data[0];
				CFG_FOUR_WAY:    four_way_q    <= cfg_data[0];
				CFG_OFFSET_BITS: offset_bits_q <= cfg_data[OB_W-1:0];
				CFG_INDEX_BITS:  index_bits_q  <= cfg_data[IB_W-1:0];
				default: ;
			endcase
		end
	end

	sactu_addr_split #(
		.SETS          (SETS),
		.ADDRESS_WIDTH (ADDRESS_WIDTH)
	) u_split (
		.clk         (clk),
		.ctl         (split_ctl),
		.action      (req.action),
		.address     (req.address),
		.split_mode  (split_mode_q),
		.offset_bits (offset_bits_q),
		.index_bits  (index_bits_q),
		.instr       (instr),
		.tag         (tag),
		.set_idx     (set_idx)
	);

	sactu_tag_ram #(
		.ROW_W (ROW_W),
		.AW    (MEM_AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr ({instr, set_idx}),
		.rdata (mem_rdata)
	);

	sactu_lookup #(
		.WAYS  (WAYS),
		.TAG_W (TAG_W),
		.ROW_W (ROW_W)
	) u_lookup (
		.row      (mem_rdata),
		.tag      (tag),
		.four_way (four_way_q),
		.hit      (look_hit),
		.way      (look_way),
		.new_row  (new_row)
	);

	sactu_counters u_counters (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cnt_ctl),
		.hits   (hits_nx),
		.misses (misses_nx)
	);

	assign out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + MEM_AW'(1);
			end
		end
	end

	always_comb begin : fsm_next
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: if (&clr_q) state_nx = ST_IDLE;
			ST_IDLE:  if (req.valid) state_nx = MOD_FREE ? ST_READ : ST_DIV;
			ST_DIV:   state_nx = ST_MOD;
			ST_MOD:   state_nx = ST_READ;
			ST_READ:  state_nx = ST_CMP;
			ST_CMP:   if (out_free) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin : fsm_outputs
		req.ready     = 1'b0;
		split_ctl     = '0;
		mem_re        = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = {instr, set_idx};
		mem_wdata     = new_row;
		cnt_ctl.upd   = 1'b0;
		cnt_ctl.instr = instr;
		cnt_ctl.hit   = look_hit;
		out_load      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				req.ready      = 1'b1;
				split_ctl.load = req.valid;
			end
			ST_DIV:  split_ctl.div = 1'b1;
			ST_MOD:  split_ctl.mod = 1'b1;
			ST_READ: mem_re = 1'b1;
			ST_CMP: begin
				// Only a miss changes the row; the write and the response go together.
				if (out_free) begin
					out_load    = 1'b1;
					mem_we      = !look_hit;
					cnt_ctl.upd = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_q         <= look_hit;
			instr_q       <= instr;
			way_q         <= look_way;
			set_index_q   <= SET_OUT_W'(set_idx);
			side_hits_q   <= hits_nx;
			side_misses_q <= misses_nx;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.hit              = hit_q;
	assign rsp.instruction_side = instr_q;
	assign rsp.way              = way_q;
	assign rsp.set_index        = set_index_q;
	assign rsp.side_hits        = side_hits_q;
	assign rsp.side_misses      = side_misses_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q != ST_IDLE))
		else $error("accepted request did not start a lookup");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |-> !out_load)
		else $error("pending response overwritten");

	a_write_only_clear_or_fill: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == ST_CLEAR) || (out_load && !look_hit)))
		else $error("tag memory written outside clearing or a miss fill");

	a_load_gives_response: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> rsp_valid_q)
		else $error("finished lookup gave no response");

endmodule

// File: hw/rtl/sactu_tag_ram.sv
// Single-port-write, single-port-read tag memory with registered read data.
// One row per set and side: round-robin pointer, valid bits and all way tags.
module sactu_tag_ram #(
	parameter int ROW_W = 134,
	parameter int AW    = 11
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [ROW_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [ROW_W-1:0] rdata
);

	logic [ROW_W-1:0] mem_q [2**AW];
	logic [ROW_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// Read data holds until the next read, so a stalled lookup keeps its row.
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/sactu_addr_split.sv
// Splits the request address into side, set and tag, reducing the index modulo the set count.
// Depends on sactu_pkg; steps are driven by the control sequencer in the top level.
module sactu_addr_split import sactu_pkg::*; #(
	parameter int SETS          = SETS_DEF,
	parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEF
) (
	input  logic                             clk,
	input  split_ctl_t                       ctl,
	input  logic [ACTION_W-1:0]              action,
	input  logic [ADDR_IN_W-1:0]             address,
	input  logic                             split_mode,
	input  logic [OB_W-1:0]                  offset_bits,
	input  logic [IB_W-1:0]                  index_bits,
	output logic                             instr,
	output logic [sactu_tag_w(ADDRESS_WIDTH)-1:0] tag,
	output logic [sactu_idx_w(SETS)-1:0]     set_idx
);

	localparam int TAG_W  = sactu_tag_w(ADDRESS_WIDTH);
	localparam int IDX_W  = sactu_idx_w(SETS);
	localparam int PROD_W = RAW_W + 33;
	// Rounded-up reciprocal; with a 15-bit index the truncated quotient is exact.
	localparam longint unsigned RECIP_L = ((64'd1 << 32) + longint'(SETS) - 1) / longint'(SETS);
	localparam logic [32:0] RECIP = 33'(RECIP_L);

	logic [TAG_W-1:0]  addr_m;
	logic [RAW_W-1:0]  raw_w;
	logic [5:0]        tag_sh;
	logic [TAG_W-1:0]  tag_w;
	logic [PROD_W-1:0] prod;

	logic              instr_q;
	logic [TAG_W-1:0]  tag_q;
	logic [RAW_W-1:0]  raw_q;
	logic [RAW_W-1:0]  quot_q;
	logic [IDX_W-1:0]  set_q;

	always_comb begin
		addr_m = address[TAG_W-1:0];
		raw_w  = RAW_W'(addr_m >> offset_bits) & ~({RAW_W{1'b1}} << index_bits);
		tag_sh = {1'b0, offset_bits} + 6'(index_bits);
		tag_w  = addr_m >> tag_sh;
		prod   = PROD_W'(raw_q) * PROD_W'(RECIP);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			instr_q <= split_mode && (action == ACT_INSTR_FETCH);
			tag_q   <= tag_w;
			raw_q   <= raw_w;
			// Already final when the set count is a power of two.
			set_q   <= IDX_W'(raw_w);
		end
		if (ctl.div) begin
			quot_q <= RAW_W'(prod >> 32);
		end
		if (ctl.mod) begin
			set_q <= IDX_W'(32'(raw_q) - 32'(quot_q) * 32'(SETS));
		end
	end

	assign instr   = instr_q;
	assign tag     = tag_q;
	assign set_idx = set_q;

endmodule

// File: hw/rtl/sactu_lookup.sv
// Tag compare, hit way selection and round-robin fill of one memory row.
// Depends on sactu_pkg; row layout is {pointer, valid bits, way tags}.
module sactu_lookup import sactu_pkg::*; #(
	parameter int WAYS  = WAYS_DEF,
	parameter int TAG_W = 32,
	parameter int ROW_W = 134
) (
	input  logic [ROW_W-1:0]     row,
	input  logic [TAG_W-1:0]     tag,
	input  logic                 four_way,
	output logic                 hit,
	output logic [WAY_OUT_W-1:0] way,
	output logic [ROW_W-1:0]     new_row
);

	localparam int PTR_W = sactu_ptr_w(WAYS);
	localparam logic [PTR_W:0] LAST_WAY = (PTR_W + 1)'(WAYS - 1);

	logic [PTR_W-1:0] ptr;
	logic [PTR_W-1:0] ptr_nx;
	logic [PTR_W-1:0] victim;
	logic [PTR_W-1:0] hit_way;
	logic [WAYS-1:0]  valid;
	logic             found;

	always_comb begin
		ptr   = row[ROW_W-1 -: PTR_W];
		valid = row[WAYS*TAG_W +: WAYS];

		// Lowest matching way wins; direct-mapped mode looks at way 0 only.
		found   = 1'b0;
		hit_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!found && (four_way || (w == 0)) && valid[w] &&
				(row[w*TAG_W +: TAG_W] == tag)) begin
				found   = 1'b1;
				hit_way = PTR_W'(w);
			end
		end

		victim = four_way ? ptr : '0;
		if (four_way) begin
			ptr_nx = ({1'b0, ptr} == LAST_WAY) ? '0 : ptr + PTR_W'(1);
		end else begin
			ptr_nx = ptr;
		end

		new_row = row;
		if (!found) begin
			for (int w = 0; w < WAYS; w++) begin
				if (PTR_W'(w) == victim) begin
					new_row[w*TAG_W +: TAG_W] = tag;
					new_row[WAYS*TAG_W + w]   = 1'b1;
				end
			end
			new_row[ROW_W-1 -: PTR_W] = ptr_nx;
		end

		hit = found;
		way = WAY_OUT_W'(found ? hit_way : victim);
	end

endmodule

// File: hw/rtl/sactu_counters.sv
// Saturating hit and miss counters for the data and instruction sides.
// Depends on sactu_pkg; gives the counts of the selected side after the update.
module sactu_counters import sactu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cnt_ctl_t           ctl,
	output logic [COUNT_W-1:0] hits,
	output logic [COUNT_W-1:0] misses
);

	logic [COUNT_W-1:0] dhit_q, dmiss_q, ihit_q, imiss_q;
	logic [COUNT_W-1:0] hits_cur, misses_cur;

	function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] c);
		return (&c) ? c : c + COUNT_W'(1);
	endfunction

	always_comb begin
		hits_cur   = ctl.instr ? ihit_q : dhit_q;
		misses_cur = ctl.instr ? imiss_q : dmiss_q;
		hits       = ctl.hit ? sat_inc(hits_cur) : hits_cur;
		misses     = ctl.hit ? misses_cur : sat_inc(misses_cur);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dhit_q  <= '0;
			dmiss_q <= '0;
			ihit_q  <= '0;
			imiss_q <= '0;
		end else if (ctl.upd) begin
			if (ctl.instr) begin
				ihit_q  <= hits;
				imiss_q <= misses;
			end else begin
				dhit_q  <= hits;
				dmiss_q <= misses;
			end
		end
	end

endmodule
